[rtl/bpt_pkg.sv]
`timescale 1ns / 1ps
package bpt_pkg;
  localparam int unsigned PARAM_ONE = 32768;
  localparam logic [4:0] DIV_RESET = 5'd7;
  localparam logic [1:0] BERN_SCALE = 2'd3;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STRIP = 1'b1;

  // Bernstein weights for one parameter, Q2.30
  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
  } weights_t;
endpackage

[rtl/bpt_mul.sv]
`timescale 1ns / 1ps
module bpt_mul (
  input  logic               clk,
  input  logic signed [33:0] a,
  input  logic signed [33:0] b,
  output logic signed [63:0] p
);
  import bpt_pkg::*;
  always_ff @(posedge clk) begin
    p <= 64'(a * b);
  end
endmodule

[rtl/bezier_patch_tessellator.sv]
`timescale 1ns / 1ps
// Cubic Bezier patch tessellator.
// s_axis: words with tuser = opcode. tdata carries grid_row, grid_col,
// point_x, point_y, point_z and strip_index, lowest bit first. Opcode 0
// loads one control point into the 4x4 grid; opcode 1 asks for strip k.
// m_axis: one word per strip vertex, two per row j = 0..divisions, tlast on
// the final one and tuser set on the single word of an invalid request.
// cfg: a write of divisions (reset 7).
// A strip runs through one shared multiplier under a sequencer: each
// parameter takes 22 divider steps and then its four weights, so the two
// column parameters are followed by 24 row evaluations, then each row j
// computes t and its weights and then two vertices of three four-term sums.
// The block takes no new word until the last result of a request has left.
// A stalled receiver holds the output register and the sequencer waits at its next output.
// Reset clears the grid, sets divisions to 7 and empties the output.
module bezier_patch_tessellator #(
  parameter int MAX_DIVISIONS = 31,
  parameter int COORD_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // grid_row, grid_col, point_x, point_y, point_z, strip_index, pad
  input  logic [8*((4+3*COORD_WIDTH+5+7)/8)-1:0] s_axis_tdata,
  input  logic                      s_axis_tuser, // opcode
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // vertex_x, vertex_y, vertex_z, tex_s, tex_t, pad
  output logic [8*((3*COORD_WIDTH+32+7)/8)-1:0] m_axis_tdata,
  output logic                      m_axis_tlast,
  output logic                      m_axis_tuser, // bad_request
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [4:0]                cfg_data
);
  import bpt_pkg::*;
  localparam int CW = COORD_WIDTH;
  localparam int OW = 8*((3*CW+32+7)/8);

  typedef enum logic [3:0] {
    S_IDLE, S_PARAM, S_WGT, S_ROWMAC, S_ROWFIN,
    S_VMAC, S_VFIN, S_OUT, S_WAIT
  } state_t;

  state_t state;
  logic [4:0] divisions;
  logic [4:0] d_eff;
  logic signed [CW-1:0] cpx [16];
  logic signed [CW-1:0] cpy [16];
  logic signed [CW-1:0] cpz [16];
  logic signed [CW-1:0] rowv [2][3][4];
  logic signed [CW-1:0] vx, vy, vz;
  logic [4:0] kreg, jreg;
  logic [15:0] s0, s1, tcur;
  // divider
  logic [21:0] num, rem;
  logic [4:0]  dstep;
  logic [15:0] quo;
  logic [1:0]  ptarget; // 0:s0 1:s1 2:t
  // weight build
  logic [2:0] wstep;
  logic [31:0] w [4];
  logic [63:0] tmpa, tmpb;
  // mac
  logic [1:0] side;
  logic [1:0] axis;
  logic [1:0] ridx;
  logic [2:0] term;
  logic signed [63:0] acc;
  logic [1:0] mwait;
  logic signed [33:0] ma, mb;
  logic signed [63:0] mp;
  logic obad;

  bpt_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  assign d_eff = (divisions > 5'(MAX_DIVISIONS)) ? 5'(MAX_DIVISIONS) : divisions;
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign cfg_ready = (state == S_IDLE);

  logic [15:0] uu, vv;
  logic signed [CW-1:0] pcur;
  logic signed [63:0] biased;
  logic signed [CW-1:0] satv;
  logic [3:0] gidx;

  always_comb begin
    uu = (ptarget == 2'd2) ? tcur : (side[0] ? s1 : s0);
    vv = 16'(PARAM_ONE - 32'(uu));
    gidx = {ridx, term[1:0]};
    if (state == S_ROWMAC)
      unique case (axis)
        2'd0: pcur = cpx[gidx];
        2'd1: pcur = cpy[gidx];
        default: pcur = cpz[gidx];
      endcase
    else
      pcur = rowv[side[0]][axis][term[1:0]];
    biased = (acc + 64'sd536870912) >>> 30;
    if (biased > 64'sd0 + ((64'sd1 <<< (CW-1)) - 1))
      satv = {1'b0, {(CW-1){1'b1}}};
    else if (biased < -(64'sd1 <<< (CW-1)))
      satv = {1'b1, {(CW-1){1'b0}}};
    else
      satv = CW'(biased);
    ma = '0;
    mb = '0;
    unique case (state)
      S_WGT: begin
        unique case (wstep)
          3'd0: begin ma = 34'(uu); mb = 34'(uu); end
          3'd1: begin ma = 34'(tmpa); mb = 34'(uu); end
          3'd2: begin ma = 34'(tmpa); mb = 34'(vv); end
          3'd3: begin ma = 34'(vv); mb = 34'(vv); end
          3'd4: begin ma = 34'(tmpa); mb = 34'(uu); end
          default: begin ma = 34'(tmpa); mb = 34'(vv); end
        endcase
      end
      S_ROWMAC, S_VMAC: begin
        ma = 34'(pcur);
        mb = $signed({2'b0, w[term[1:0]]});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      divisions <= DIV_RESET;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        cpx[i] <= '0; cpy[i] <= '0; cpz[i] <= '0;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) divisions <= cfg_data;
          if (s_axis_tvalid && s_axis_tready) begin
            if (s_axis_tuser == OP_LOAD) begin
              cpx[{s_axis_tdata[1:0], s_axis_tdata[3:2]}] <= s_axis_tdata[4 +: CW];
              cpy[{s_axis_tdata[1:0], s_axis_tdata[3:2]}] <= s_axis_tdata[4+CW +: CW];
              cpz[{s_axis_tdata[1:0], s_axis_tdata[3:2]}] <= s_axis_tdata[4+2*CW +: CW];
            end else begin
              kreg <= s_axis_tdata[4+3*CW +: 5];
              if (s_axis_tdata[4+3*CW +: 5] == 5'd0 ||
                  s_axis_tdata[4+3*CW +: 5] > d_eff) begin
                obad <= 1'b1;
                m_axis_tdata <= '0;
                m_axis_tlast <= 1'b1;
                state <= S_WAIT;
              end else begin
                obad <= 1'b0;
                num <= 22'({s_axis_tdata[4+3*CW +: 5] - 5'd1, 16'h0}) + 22'(d_eff);
                rem <= '0; dstep <= '0; quo <= '0;
                ptarget <= 2'd0;
                state <= S_PARAM;
              end
            end
          end
        end
        S_PARAM: begin
          // one restoring step of (2n*32768 + d) / (2d)
          if ({rem[20:0], num[21]} >= 22'({d_eff, 1'b0})) begin
            rem <= {rem[20:0], num[21]} - 22'({d_eff, 1'b0});
            quo <= {quo[14:0], 1'b1};
          end else begin
            rem <= {rem[20:0], num[21]};
            quo <= {quo[14:0], 1'b0};
          end
          num <= {num[20:0], 1'b0};
          dstep <= dstep + 5'd1;
          if (dstep == 5'd21) begin
            state <= S_WGT;
            wstep <= '0; mwait <= '0;
            if (ptarget == 2'd0) begin
              s0 <= ({rem[20:0], num[21]} >= 22'({d_eff, 1'b0})) ?
                    {quo[14:0], 1'b1} : {quo[14:0], 1'b0};
              side <= 2'd0;
            end else if (ptarget == 2'd1) begin
              s1 <= ({rem[20:0], num[21]} >= 22'({d_eff, 1'b0})) ?
                    {quo[14:0], 1'b1} : {quo[14:0], 1'b0};
              side <= 2'd1;
            end else begin
              tcur <= ({rem[20:0], num[21]} >= 22'({d_eff, 1'b0})) ?
                      {quo[14:0], 1'b1} : {quo[14:0], 1'b0};
            end
          end
        end
        S_WGT: begin
          // multiply, then wait for the product register
          if (mwait == 2'd0) mwait <= 2'd1;
          else begin
            mwait <= 2'd0;
            wstep <= wstep + 3'd1;
            unique case (wstep)
              3'd0: tmpa <= mp;                      // u^2
              3'd1: begin w[0] <= 32'((mp + 64'd16384) >> 15); tmpa <= tmpa * 64'(BERN_SCALE); end
              3'd2: begin w[1] <= 32'((mp + 64'd16384) >> 15); end
              3'd3: begin tmpa <= mp; tmpb <= mp; end // v^2
              3'd4: begin w[2] <= 32'((64'(BERN_SCALE) * mp + 64'd16384) >> 15); tmpa <= tmpb; end
              default: begin
                w[3] <= 32'((mp + 64'd16384) >> 15);
                axis <= '0; ridx <= '0; term <= '0; acc <= '0;
                state <= (ptarget == 2'd2) ? S_VMAC : S_ROWMAC;
              end
            endcase
          end
        end
        S_ROWMAC, S_VMAC: begin
          if (mwait == 2'd0) mwait <= 2'd1;
          else begin
            mwait <= 2'd0;
            acc <= acc + mp;
            term <= term + 3'd1;
            if (term == 3'd3) state <= (state == S_ROWMAC) ? S_ROWFIN : S_VFIN;
          end
        end
        S_ROWFIN: begin
          rowv[side[0]][axis][ridx] <= satv;
          acc <= '0; term <= '0;
          state <= S_ROWMAC;
          if (axis == 2'd2) begin
            axis <= '0;
            if (ridx == 2'd3) begin
              if (side == 2'd0) begin
                num <= 22'({kreg, 16'h0}) + 22'(d_eff);
                rem <= '0; dstep <= '0; quo <= '0;
                ptarget <= 2'd1;
                state <= S_PARAM;
              end else begin
                jreg <= '0;
                side <= 2'd0;
                num <= 22'(d_eff);
                rem <= '0; dstep <= '0; quo <= '0;
                ptarget <= 2'd2;
                state <= S_PARAM;
              end
            end else ridx <= ridx + 2'd1;
          end else axis <= axis + 2'd1;
        end
        S_VFIN: begin
          unique case (axis)
            2'd0: vx <= satv;
            2'd1: vy <= satv;
            default: vz <= satv;
          endcase
          acc <= '0; term <= '0;
          if (axis == 2'd2) state <= S_OUT;
          else begin axis <= axis + 2'd1; state <= S_VMAC; end
        end
        S_OUT: begin
          if (!m_axis_tvalid) begin
            m_axis_tdata <= OW'({tcur, side[0] ? s1 : s0, vz, vy, vx});
            m_axis_tlast <= side[0] && (jreg == d_eff);
            m_axis_tvalid <= 1'b1;
            axis <= '0;
            if (!side[0]) begin
              side <= 2'd1;
              state <= S_VMAC;
            end else if (jreg == d_eff) begin
              state <= S_IDLE;
            end else begin
              side <= 2'd0;
              jreg <= jreg + 5'd1;
              num <= 22'({jreg + 5'd1, 16'h0}) + 22'(d_eff);
              rem <= '0; dstep <= '0; quo <= '0;
              state <= S_PARAM;
            end
          end
        end
        S_WAIT: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tuser = obad;

  a_bad_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast) else $error("bad word without tlast");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("output dropped");
  a_tex: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[3*CW+16 +: 16] <= 16'd32768)
    else $error("tex_t out of range");
endmodule
